FILE: sv/positional_sequence_store_core_defines.svh
// assertion macros for the positional sequence store
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH
`define PSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/pss_pkg.sv
// package for the positional sequence store: types and codes
package pss_pkg;
  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT     = 3'd0,
    CMD_INSERT_SORTED = 3'd1,
    CMD_ERASE_AT      = 3'd2,
    CMD_REMOVE_ALL    = 3'd3,
    CMD_GET           = 3'd4,
    CMD_SET           = 3'd5,
    CMD_FIND          = 3'd6,
    CMD_NOP           = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_PUT, S_DONE
  } state_t;
endpackage

FILE: sv/positional_sequence_store_core.sv
// positional sequence store: command sequencer around one entry memory
// insert_at walks the entries from pos up to len, erase from pos+1 up to len, find
// and remove_all walk the sequence from its start, and sorted insert scans and then
// shifts, one memory entry per cycle; set, no-op and rejected commands walk none
// busy is high from acceptance until the result strobe, and the next start is taken
// in idle; the receiver cannot stall: the result stands for exactly one cycle
// rst_n synchronous active low clears length and control; entries stay unset
module positional_sequence_store_core #(
  parameter int unsigned CAPACITY    = pss_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = pss_pkg::VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [pss_pkg::CMD_W-1:0] in_command,
  input  logic [pss_pkg::POS_W-1:0] in_position,
  input  logic [pss_pkg::VAL_W-1:0] in_item_value,
  output logic                      out_valid,
  output logic [pss_pkg::ST_W-1:0]  out_status,
  output logic [pss_pkg::POS_W-1:0] out_result_index,
  output logic [pss_pkg::VAL_W-1:0] out_result_value,
  output logic [pss_pkg::POS_W-1:0] out_removed_count,
  output logic [pss_pkg::POS_W-1:0] out_current_length
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = (VALUE_WIDTH < pss_pkg::VAL_W) ? VALUE_WIDTH : pss_pkg::VAL_W;

  pss_pkg::state_t state_r, state_nxt;
  pss_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] pos_r, pos_nxt;     // target slot / start index
  logic [LW-1:0] rd_r, rd_nxt;       // read index
  logic [LW-1:0] wr_r, wr_nxt;       // write index for compaction
  logic          rv_r, rv_nxt;       // read issued last cycle
  logic [LW-1:0] ri_r, ri_nxt;       // index of that read
  logic [VW-1:0] val_r, val_nxt;
  logic [VW-1:0] hold_r, hold_nxt;   // carried word for upward shift
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [pss_pkg::ST_W-1:0] st_r, st_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] rval_r, rval_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  pss_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [LW:0] pos_in;
  assign pos_in = {{(LW+1-pss_pkg::POS_W > 0 ? LW+1-pss_pkg::POS_W : 0){1'b0}},
                   in_position} ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pss_pkg::S_IDLE;
      len_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rv_r    <= rv_nxt;
    end
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    ri_r   <= ri_nxt;
    val_r  <= val_nxt;
    hold_r <= hold_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    idx_r  <= idx_nxt;
    rval_r <= rval_nxt;
  end

  // next state and datapath
  always_comb begin
    logic [LW+pss_pkg::POS_W:0] pw;
    pw = '0;
    state_nxt = state_r;
    cmd_nxt = cmd_r; len_nxt = len_r; pos_nxt = pos_r; rd_nxt = rd_r; wr_nxt = wr_r;
    rv_nxt = 1'b0; ri_nxt = rd_r; val_nxt = val_r; hold_nxt = hold_r; cnt_nxt = cnt_r;
    st_nxt = st_r; idx_nxt = idx_r; rval_nxt = rval_r;
    we = 1'b0; waddr = '0; wdata = val_r; raddr = rd_r[AW-1:0];
    case (state_r)
      pss_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = pss_pkg::cmd_t'(in_command);
          val_nxt = in_item_value[VW-1:0];
          st_nxt = pss_pkg::ST_OK; idx_nxt = '0; rval_nxt = '0; cnt_nxt = '0;
          rd_nxt = '0; wr_nxt = '0;
          pos_nxt = pos_in[LW-1:0];
          pw = {{(LW+1){1'b0}}, in_position};
          state_nxt = pss_pkg::S_DONE;
          case (pss_pkg::cmd_t'(in_command))
            pss_pkg::CMD_INSERT_AT: begin
              if (pw > (LW+pss_pkg::POS_W+1)'(len_r)) st_nxt = pss_pkg::ST_BADPOS;
              else if ({1'b0, len_r} >= (LW+1)'(CAPACITY)) st_nxt = pss_pkg::ST_FULL;
              else begin
                idx_nxt = pos_in[LW-1:0];
                rd_nxt = pos_in[LW-1:0];
                state_nxt = pss_pkg::S_SHUP;
              end
            end
            pss_pkg::CMD_INSERT_SORTED: begin
              if ({1'b0, len_r} >= (LW+1)'(CAPACITY)) st_nxt = pss_pkg::ST_FULL;
              else state_nxt = pss_pkg::S_SCAN;
            end
            pss_pkg::CMD_ERASE_AT, pss_pkg::CMD_GET, pss_pkg::CMD_SET: begin
              if (pw >= (LW+pss_pkg::POS_W+1)'(len_r)) st_nxt = pss_pkg::ST_BADPOS;
              else if (pss_pkg::cmd_t'(in_command) == pss_pkg::CMD_SET) begin
                we = 1'b1; waddr = pos_in[AW-1:0]; wdata = in_item_value[VW-1:0];
              end else if (pss_pkg::cmd_t'(in_command) == pss_pkg::CMD_GET) begin
                raddr = pos_in[AW-1:0]; rv_nxt = 1'b1; state_nxt = pss_pkg::S_PUT;
              end else begin
                rd_nxt = pos_in[LW-1:0] + 1'b1; wr_nxt = pos_in[LW-1:0];
                state_nxt = pss_pkg::S_SHDN;
              end
            end
            pss_pkg::CMD_REMOVE_ALL: state_nxt = pss_pkg::S_SHDN;
            pss_pkg::CMD_FIND: begin
              st_nxt = pss_pkg::ST_NOTFOUND; state_nxt = pss_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      pss_pkg::S_PUT: begin
        if (rv_r) rval_nxt = rdata;
        state_nxt = pss_pkg::S_DONE;
      end
      // search for first match (find) or first entry >= value (sorted insert)
      pss_pkg::S_SCAN: begin
        if (rv_r && ((cmd_r == pss_pkg::CMD_FIND) ? (rdata == val_r) : (rdata >= val_r))) begin
          if (cmd_r == pss_pkg::CMD_FIND) begin
            st_nxt = pss_pkg::ST_OK; idx_nxt = ri_r; state_nxt = pss_pkg::S_DONE;
          end else begin
            idx_nxt = ri_r; pos_nxt = ri_r; rd_nxt = ri_r; state_nxt = pss_pkg::S_SHUP;
          end
        end else if (rd_r < len_r) begin
          raddr = rd_r[AW-1:0]; rv_nxt = 1'b1; ri_nxt = rd_r; rd_nxt = rd_r + 1'b1;
        end else if (!rv_r || rd_r == len_r) begin
          if (cmd_r == pss_pkg::CMD_FIND) state_nxt = pss_pkg::S_DONE;
          else begin
            idx_nxt = len_r; pos_nxt = len_r; rd_nxt = len_r; state_nxt = pss_pkg::S_SHUP;
          end
        end
      end
      // walk up from pos: write carried word, pick up old one
      pss_pkg::S_SHUP: begin
        if (rd_r == pos_r && !rv_r) begin
          hold_nxt = val_r;
          if (rd_r < len_r) begin
            raddr = rd_r[AW-1:0]; rv_nxt = 1'b1; ri_nxt = rd_r; rd_nxt = rd_r + 1'b1;
          end else begin
            we = 1'b1; waddr = rd_r[AW-1:0]; wdata = val_r;
            len_nxt = len_r + 1'b1; state_nxt = pss_pkg::S_DONE;
          end
        end else begin
          we = 1'b1; waddr = ri_r[AW-1:0]; wdata = hold_r; hold_nxt = rdata;
          if (rd_r < len_r) begin
            raddr = rd_r[AW-1:0]; rv_nxt = 1'b1; ri_nxt = rd_r; rd_nxt = rd_r + 1'b1;
          end else begin
            // final word goes to slot len on the next pass
            pos_nxt = len_r; rd_nxt = len_r; val_nxt = rdata;
            hold_nxt = rdata;
          end
          if (rd_r >= len_r) begin
            state_nxt = pss_pkg::S_PUT;
            len_nxt = len_r;
          end
        end
      end
      // compaction: erase one slot or drop matches
      pss_pkg::S_SHDN: begin
        if (rv_r) begin
          if (cmd_r == pss_pkg::CMD_REMOVE_ALL && rdata == val_r) cnt_nxt = cnt_r + 1'b1;
          else begin
            we = 1'b1; waddr = wr_r[AW-1:0]; wdata = rdata; wr_nxt = wr_r + 1'b1;
          end
        end
        if (rd_r < len_r) begin
          raddr = rd_r[AW-1:0]; rv_nxt = 1'b1; ri_nxt = rd_r; rd_nxt = rd_r + 1'b1;
        end else if (!rv_r) begin
          if (cmd_r == pss_pkg::CMD_REMOVE_ALL) len_nxt = wr_r;
          else len_nxt = len_r - 1'b1;
          state_nxt = pss_pkg::S_DONE;
        end
      end
      pss_pkg::S_DONE: state_nxt = pss_pkg::S_IDLE;
      default: state_nxt = pss_pkg::S_IDLE;
    endcase
    // upward shift tail: last carried word written into slot len
    if (state_r == pss_pkg::S_PUT && cmd_r != pss_pkg::CMD_GET) begin
      we = 1'b1; waddr = len_r[AW-1:0]; wdata = hold_r;
      len_nxt = len_r + 1'b1; rval_nxt = rval_r;
    end
  end

  // outputs
  always_comb begin
    busy = (state_r != pss_pkg::S_IDLE);
    out_valid = (state_r == pss_pkg::S_DONE);
    out_status = st_r;
    out_result_index = pss_pkg::POS_W'(idx_r);
    out_result_value = pss_pkg::VAL_W'(rval_r);
    out_removed_count = pss_pkg::POS_W'(cnt_r);
    out_current_length = pss_pkg::POS_W'(len_r);
  end
endmodule

FILE: sv/pss_ram.sv
// generic ram with separate write and read ports and registered read
module pss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/pss_checker.sv
// port checker for the positional sequence store, bound to the core module
`include "positional_sequence_store_core_defines.svh"
module pss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [6:0] out_current_length
);
  `PSS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted word must raise busy")
  `PSS_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy, "result outside busy")
  `PSS_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid && !busy, "result not single")
  `PSS_ASSERT_IMPL(a_len_cap, clk, rst_n, out_valid, out_current_length <= 7'd64, "length past capacity")
  `PSS_ASSERT_IMPL(a_full_len, clk, rst_n, out_valid && out_status == pss_pkg::ST_FULL, out_current_length == 7'd64, "full status below capacity")
endmodule

bind positional_sequence_store_core pss_checker u_pss_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_current_length(out_current_length)
);
